FILE: rtl/ffd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffd_pkg;
  typedef struct packed {
    logic [15:0] item_size;
    logic        last_item;
  } ffd_in_t;

  typedef struct packed {
    logic [5:0]  item_index;
    logic [15:0] assigned_size;
    logic [5:0]  bin_number;
    logic        oversize;
    logic        items_dropped;
    logic        last_result;
  } ffd_out_t;

  localparam int          SIZE_BITS = 16;
  localparam logic [15:0] CAP_RESET = 16'hFFFF;
  localparam int unsigned REG_CAP = 0;
endpackage
`default_nettype wire

FILE: rtl/first_fit_decreasing_bin_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: one item per cycle into an insertion-sort chain of MAX_ITEMS cells.
// Pack: after the last item, one result per cycle leaves the sort chain
//   head while the output register is free (out_stall low or no result
//   held) and is placed in a row of MAX_ITEMS bin cells; results pass a
//   one-deep output register. in_stall is high while a set is packed.
// Reset (synchronous, rst_n low) empties both chains, capacity to 65535.
module first_fit_decreasing_bin_packer
  import ffd_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ffd_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ffd_out_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int IB = $clog2(MAX_ITEMS);
  localparam int CB = $clog2(MAX_ITEMS + 1);
  localparam int SW = SIZE_BITS;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_PACK = 1'b1;

  logic          state_r, state_nxt;
  logic [15:0]   cap_r;
  logic [CB-1:0] cnt_r;     // items held
  logic [CB-1:0] left_r;    // items still to pack
  logic          drop_r;
  logic          in_xfer, cfg_wr;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == 2'(REG_CAP * 4)) ? {16'h0, cap_r} : 32'h0;

  // sort chain
  logic [MAX_ITEMS-1:0] goes, vld;
  logic [SW-1:0]        sz  [MAX_ITEMS];
  logic [IB-1:0]        idx [MAX_ITEMS];
  logic                 store_full, ins, shl;
  logic [SW-1:0]        new_size;

  assign store_full = (cnt_r == CB'(MAX_ITEMS));
  assign in_stall   = (state_r != ST_LOAD);
  assign in_xfer    = in_valid && !in_stall;
  assign ins        = in_xfer && !store_full;
  assign new_size   = SW'(in_data.item_size);

  logic out_free, pack_step;
  assign out_free  = !out_valid || !out_stall;
  assign pack_step = (state_r == ST_PACK) && out_free && (left_r != '0);
  assign shl       = pack_step;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_sort
    ffd_sort_cell #(.IDX_BITS(IB), .SW(SW)) u_cell (
      .clk(clk), .clr(!rst_n), .ins(ins), .shl(shl),
      .new_size(new_size), .new_idx(cnt_r[IB-1:0]),
      .left_goes(i == 0 ? 1'b0 : goes[(i == 0) ? 0 : i-1]),
      .left_vld(vld[(i == 0) ? 0 : i-1]),
      .left_size(sz[(i == 0) ? 0 : i-1]),
      .left_idx(idx[(i == 0) ? 0 : i-1]),
      .right_vld(i == MAX_ITEMS-1 ? 1'b0 : vld[(i == MAX_ITEMS-1) ? i : i+1]),
      .right_size(sz[(i == MAX_ITEMS-1) ? i : i+1]),
      .right_idx(idx[(i == MAX_ITEMS-1) ? i : i+1]),
      .goes(goes[i]), .vld_r(vld[i]), .size_r(sz[i]), .idx_r(idx[i]));
  end

  // bin row: head item placed into lowest fitting bin or next new bin
  logic [MAX_ITEMS-1:0] fits, opn, take, lowest_fit;
  logic [SW-1:0]        head_size;
  logic                 any_fit, bin_clr;
  logic [IB-1:0]        fit_num;
  logic [CB-1:0]        bins_r;

  assign head_size  = sz[0];
  assign bin_clr    = !rst_n || (state_r == ST_LOAD);
  assign lowest_fit = fits & (~fits + 1'b1);
  assign any_fit    = |fits;
  always_comb begin
    fit_num = '0;
    for (int b = 0; b < MAX_ITEMS; b++) begin
      if (lowest_fit[b]) fit_num = IB'(b);
    end
  end

  for (genvar b = 0; b < MAX_ITEMS; b++) begin : g_bin
    assign take[b] = pack_step && lowest_fit[b];
    ffd_bin_cell #(.SW(SW)) u_bin (
      .clk(clk), .clr(bin_clr), .cap(cap_r), .size(head_size),
      .take(take[b]),
      .open_new(pack_step && !any_fit && (bins_r == CB'(b))),
      .fits(fits[b]), .open_r(opn[b]));
  end

  logic [IB-1:0] bin_sel;
  assign bin_sel = any_fit ? fit_num : bins_r[IB-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_xfer && in_data.last_item) state_nxt = ST_PACK;
      ST_PACK: if (pack_step && left_r == CB'(1)) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cap_r     <= CAP_RESET;
      cnt_r     <= '0;
      left_r    <= '0;
      drop_r    <= 1'b0;
      bins_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr == 2'(REG_CAP * 4)) cap_r <= cfg_pwdata[15:0];
      if (in_xfer) begin
        if (store_full) drop_r <= 1'b1;
        else cnt_r <= cnt_r + 1'b1;
        if (in_data.last_item) begin
          left_r <= store_full ? cnt_r : cnt_r + 1'b1;
        end
      end
      if (pack_step) begin
        out_valid              <= 1'b1;
        out_data.item_index    <= 6'(idx[0]);
        out_data.assigned_size <= 16'(head_size);
        out_data.bin_number    <= 6'(bin_sel);
        out_data.oversize      <= ({{(32-SW){1'b0}}, head_size} > {16'h0, cap_r});
        out_data.items_dropped <= drop_r;
        out_data.last_result   <= (left_r == CB'(1));
        left_r <= left_r - 1'b1;
        if (left_r == CB'(1)) begin
          cnt_r  <= '0;
          drop_r <= 1'b0;
          bins_r <= '0;
        end else if (!any_fit && bins_r != CB'(MAX_ITEMS)) begin
          bins_r <= bins_r + 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ffd_sort_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One slot of the insertion-sort chain. Slots hold entries ordered by size,
// largest first. A new entry enters at every slot at once; each slot keeps,
// takes the new entry, or takes its left neighbor's entry. In unload mode
// the chain shifts left by one slot.
module ffd_sort_cell #(
  parameter int IDX_BITS = 6,
  parameter int SW = 16
) (
  input  wire logic                clk,
  input  wire logic                clr,
  input  wire logic                ins,
  input  wire logic                shl,
  input  wire logic [SW-1:0]       new_size,
  input  wire logic [IDX_BITS-1:0] new_idx,
  input  wire logic                left_goes,
  input  wire logic                left_vld,
  input  wire logic [SW-1:0]       left_size,
  input  wire logic [IDX_BITS-1:0] left_idx,
  input  wire logic                right_vld,
  input  wire logic [SW-1:0]       right_size,
  input  wire logic [IDX_BITS-1:0] right_idx,
  output logic                     goes,
  output logic                     vld_r,
  output logic [SW-1:0]            size_r,
  output logic [IDX_BITS-1:0]      idx_r
);
  // new entry goes at or ahead of this slot when slot empty or strictly smaller
  assign goes = !vld_r || (size_r < new_size);

  always_ff @(posedge clk) begin
    if (clr) begin
      vld_r <= 1'b0;
    end else if (shl) begin
      vld_r  <= right_vld;
      size_r <= right_size;
      idx_r  <= right_idx;
    end else if (ins && goes) begin
      if (left_goes) begin
        size_r <= left_size;
        idx_r  <= left_idx;
        vld_r  <= left_vld;
      end else begin
        vld_r  <= 1'b1;
        size_r <= new_size;
        idx_r  <= new_idx;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ffd_bin_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One bin of the first-fit row. Holds the bin's load; reports whether the
// offered item fits. The placing logic picks the lowest fitting bin.
module ffd_bin_cell #(
  parameter int SW = 16
) (
  input  wire logic          clk,
  input  wire logic          clr,
  input  wire logic [15:0]   cap,
  input  wire logic [SW-1:0] size,
  input  wire logic          take,
  input  wire logic          open_new,
  output logic               fits,
  output logic               open_r
);
  logic [SW:0] load_r;
  logic [SW:0] spare;

  assign spare = {1'b0, SW'(cap)} - load_r;
  assign fits  = open_r && (load_r <= {1'b0, SW'(cap)}) && (spare >= {1'b0, size});

  always_ff @(posedge clk) begin
    if (clr) begin
      open_r <= 1'b0;
    end else if (open_new) begin
      open_r <= 1'b1;
      load_r <= {1'b0, size};
    end else if (take) begin
      load_r <= load_r + {1'b0, size};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ffd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ffd_checker
  import ffd_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire ffd_out_t out_data,
  input wire logic     cfg_pready
);
  a_ready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
  a_noload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> in_stall) else $error("load during pack");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");
endmodule
bind first_fit_decreasing_bin_packer ffd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
  .cfg_pready(cfg_pready));
`default_nettype wire
